>>> hw/rtl/sae_pkg.sv
package sae_pkg;

	localparam int unsigned SYMBOLS    = 256;
	localparam int unsigned FREQ_WIDTH = 16;
	localparam int unsigned TAB_DEPTH  = SYMBOLS + 1;
	localparam int unsigned TAB_AW     = $clog2(TAB_DEPTH);
	localparam int unsigned QDEPTH     = 2;
	localparam int unsigned QAW        = $clog2(QDEPTH);

	localparam logic [31:0] MASK31  = 32'h7FFF_FFFF;
	localparam logic [31:0] TOP_BIT = 32'h4000_0000;

	typedef enum logic [1:0] {
		KIND_LOAD   = 2'd0,
		KIND_ENCODE = 2'd1,
		KIND_FLUSH  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [8:0]  table_index;
		logic [15:0] table_value;
		logic [7:0]  symbol;
	} in_word_t;

	typedef struct packed {
		logic [31:0] out_bits;
		logic [5:0]  bit_count;
	} out_word_t;

	// front to back: classified command
	typedef struct packed {
		kind_t      kind;
		logic [7:0] symbol;
	} cmd_t;

endpackage

>>> hw/rtl/sae_ram.sv
module sae_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 257
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hw/rtl/sae_front.sv
// Accepts words, writes table loads, queues commands for the back end.
module sae_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sae_pkg::in_word_t           in_word,
	input  logic                        push,
	output logic                        full,
	input  logic                        tab_busy,
	output logic                        tab_we,
	output logic [sae_pkg::TAB_AW-1:0]  tab_waddr,
	output logic [15:0]                 tab_wdata,
	output logic                        cmd_valid,
	output sae_pkg::cmd_t               cmd,
	input  logic                        cmd_take
);

	sae_pkg::cmd_t              q_q [sae_pkg::QDEPTH];
	logic [sae_pkg::QAW-1:0]    wp_q, rp_q;
	logic [sae_pkg::QAW:0]      cnt_q;
	logic                       acc;
	logic                       ld_block;
	sae_pkg::cmd_t              c;

	// loads only write while the queue is empty and the table is not being read, so table reads stay ordered
	assign ld_block = (c.kind == sae_pkg::KIND_LOAD) && ((cnt_q != '0) || tab_busy);
	assign full = (cnt_q == (sae_pkg::QAW+1)'(sae_pkg::QDEPTH)) || ld_block;
	assign acc  = push && !full;
	assign c.kind   = sae_pkg::kind_t'(in_word.kind);
	assign c.symbol = in_word.symbol;

	assign tab_we    = acc && (c.kind == sae_pkg::KIND_LOAD)
		&& (in_word.table_index <= 9'(sae_pkg::SYMBOLS));
	assign tab_waddr = in_word.table_index[sae_pkg::TAB_AW-1:0];
	assign tab_wdata = in_word.table_value & 16'((32'd1 << sae_pkg::FREQ_WIDTH) - 1);

	assign cmd_valid = (cnt_q != '0);
	assign cmd       = q_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			rp_q   <= '0;
			cnt_q  <= '0;
		end else begin
			if (acc && c.kind != sae_pkg::KIND_NONE) begin
				q_q[wp_q] <= c;
				wp_q      <= wp_q + 1'b1;
			end
			if (cmd_take) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (sae_pkg::QAW+1)'(acc && c.kind != sae_pkg::KIND_NONE)
				- (sae_pkg::QAW+1)'(cmd_take);
		end
	end

endmodule

>>> hw/rtl/sae_back.sv
// Interval update with a shared restoring divider, then bit emission; flush shifts out low.
module sae_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [15:0]                 total_count,
	input  logic                        cmd_valid,
	input  sae_pkg::cmd_t               cmd,
	output logic                        cmd_take,
	output logic                        tab_re,
	output logic [sae_pkg::TAB_AW-1:0]  tab_raddr,
	input  logic [15:0]                 tab_rdata,
	output logic                        empty,
	input  logic                        pop,
	output sae_pkg::out_word_t          out_word
);

	typedef enum logic [3:0] {
		S_IDLE, S_RD0, S_RD1, S_RD2, S_MUL, S_DIV, S_UPD, S_SHIFT, S_FLUSH, S_OUT
	} state_t;

	state_t      st_q;
	sae_pkg::cmd_t cur_q;
	logic [31:0] low_q, high_q, range_q, cum0_q, width_q;
	logic [15:0] cum_s_q;
	logic        pass_q;
	logic [63:0] prod_q;
	logic [63:0] quo_q;
	logic [16:0] rem_q;
	logic [15:0] tot_q;
	logic [6:0]  it_q;
	logic [31:0] acc_q;
	logic [5:0]  n_q;
	logic        out_v_q;
	logic [31:0] out_bits_q;
	logic [5:0]  out_cnt_q;
	logic [16:0] rtry;
	logic [31:0] lnew;
	logic [7:0]  sym;

	assign sym       = cur_q.symbol;
	assign empty     = !out_v_q;
	assign out_word  = '{out_bits: out_bits_q, bit_count: out_cnt_q};
	assign cmd_take  = (st_q == S_IDLE) && cmd_valid && !out_v_q;
	assign tab_re    = (st_q == S_RD0) || (st_q == S_RD1);
	assign tab_raddr = (st_q == S_RD0) ? sae_pkg::TAB_AW'(sym) : sae_pkg::TAB_AW'(sym) + 1'b1;
	assign rtry      = {rem_q[15:0], quo_q[63]} - {1'b0, tot_q};
	assign lnew      = (low_q + quo_q[31:0]) & sae_pkg::MASK31;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			low_q   <= '0;
			high_q  <= sae_pkg::MASK31;
			out_v_q <= 1'b0;
		end else begin
			if (pop && out_v_q && st_q != S_OUT) begin
				out_v_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (cmd_take) begin
						cur_q <= cmd;
						acc_q <= '0;
						n_q   <= '0;
						tot_q <= (total_count == '0) ? 16'd1 : total_count;
						priority case (cmd.kind)
							sae_pkg::KIND_ENCODE: st_q <= S_RD0;
							sae_pkg::KIND_FLUSH: begin
								low_q <= (low_q + ((high_q + 32'd1 - low_q) >> 1))
									& sae_pkg::MASK31;
								st_q  <= S_FLUSH;
							end
							default: st_q <= S_OUT;
						endcase
					end
				end
				S_RD0: st_q <= S_RD1;
				S_RD1: begin
					cum_s_q <= tab_rdata;
					range_q <= high_q - low_q - 32'd1;
					st_q    <= S_RD2;
				end
				S_RD2: begin
					cum0_q  <= {16'd0, cum_s_q};
					width_q <= {16'd0, tab_rdata} - {16'd0, cum_s_q} - 32'd1;
					pass_q  <= 1'b0;
					st_q    <= S_MUL;
				end
				S_MUL: begin
					prod_q <= (pass_q ? width_q : cum0_q) * range_q;
					st_q   <= S_DIV;
					it_q   <= '0;
					rem_q  <= '0;
				end
				S_DIV: begin
					if (it_q == 7'd0) begin
						quo_q <= prod_q;
					end
					if (it_q != 7'd0) begin
						if (!rtry[16]) begin
							rem_q <= rtry;
							quo_q <= {quo_q[62:0], 1'b1};
						end else begin
							rem_q <= {rem_q[15:0], quo_q[63]};
							quo_q <= {quo_q[62:0], 1'b0};
						end
					end
					it_q <= it_q + 1'b1;
					if (it_q == 7'd64) begin
						st_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (!pass_q) begin
						low_q  <= lnew;
						pass_q <= 1'b1;
						st_q   <= S_MUL;
					end else begin
						high_q <= lnew;
						st_q   <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (((low_q ^ high_q) & sae_pkg::TOP_BIT) == '0) begin
						acc_q  <= {acc_q[30:0], low_q[30]};
						n_q    <= n_q + 1'b1;
						low_q  <= {low_q[30:0], 1'b0} & sae_pkg::MASK31;
						high_q <= {high_q[30:0], 1'b1} & sae_pkg::MASK31;
					end else begin
						st_q <= S_OUT;
					end
				end
				S_FLUSH: begin
					if (low_q != '0) begin
						acc_q <= {acc_q[30:0], low_q[30]};
						n_q   <= n_q + 1'b1;
						low_q <= {low_q[30:0], 1'b0} & sae_pkg::MASK31;
					end else begin
						high_q <= sae_pkg::MASK31;
						st_q   <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_v_q || pop) begin
						out_v_q    <= 1'b1;
						out_bits_q <= acc_q;
						out_cnt_q  <= n_q;
						st_q       <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> hw/rtl/static_arithmetic_encoder.sv
// channel | direction | handshake      | word
// input   | in        | push / full    | in_word (in_word_t)
// result  | out       | pop / empty    | out_word (out_word_t)
// config  | in        | cfg_we         | cfg_data (total_count)
// From accept to result: a load goes straight to output; an encode reads the table,
// runs two passes of the bit-serial divider, then shifts out bits; flush shifts out low.
// Reset is asynchronous and gives low 0, high 0x7FFFFFFF, total 1.
// A two-word command queue separates intake from the coder; full stalls push,
// and a load also waits until the queue is empty and the table is not being read.
module static_arithmetic_encoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  sae_pkg::in_word_t    in_word,
	output logic                 empty,
	input  logic                 pop,
	output sae_pkg::out_word_t   out_word,
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_data
);

	logic [15:0]                total_q;
	logic                       tab_we, tab_re, cmd_valid, cmd_take;
	logic [sae_pkg::TAB_AW-1:0] tab_waddr, tab_raddr;
	logic [15:0]                tab_wdata, tab_rdata;
	sae_pkg::cmd_t              cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= 16'd1;
		end else if (cfg_we) begin
			total_q <= cfg_data;
		end
	end

	sae_front u_front (
		.clk, .arst_n, .in_word, .push, .full, .tab_busy(tab_re),
		.tab_we, .tab_waddr, .tab_wdata, .cmd_valid, .cmd, .cmd_take
	);

	sae_ram #(.WIDTH(16), .DEPTH(sae_pkg::TAB_DEPTH)) u_tab (
		.clk, .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
		.re(tab_re), .raddr(tab_raddr), .rdata(tab_rdata)
	);

	sae_back u_back (
		.clk, .arst_n, .total_count(total_q), .cmd_valid, .cmd, .cmd_take,
		.tab_re, .tab_raddr, .tab_rdata, .empty, .pop, .out_word
	);

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> out_word.bit_count <= 6'd32) else $error("bit count");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> cmd_valid) else $error("take empty queue");
	a_bits: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_word.bit_count == 6'd0) |-> out_word.out_bits == '0)
		else $error("stray bits");

endmodule
